@@ hw/rtl/spf_pkg.sv @@
// ----------------------------------------------------------------------------
// spf_pkg: shared definitions of the scanline polygon fill unit
// Default sizes, the separator coordinate, datapath commands and the
// status word that the datapath returns to the controller.
// ----------------------------------------------------------------------------
package spf_pkg;

  localparam int MaxEdgesDefault = 64;
  localparam int FracBitsDefault = 16;
  localparam int MaxSpans        = 32;
  localparam int KW              = $clog2(MaxSpans + 1);
  localparam logic signed [15:0] Separator = 16'sh7FFF;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_VERTEX,
    CMD_EDGE_WRITE,
    CMD_IDLE_PUT,
    CMD_RENDER_START,
    CMD_SCAN_RD,
    CMD_SCAN_SKIP,
    CMD_SCAN_TAKE,
    CMD_FIND_RD,
    CMD_FIND_NEXT,
    CMD_FIND_STOP,
    CMD_SHIFT_RD,
    CMD_SHIFT_WR,
    CMD_INSERT,
    CMD_EMIT_START,
    CMD_EMIT_RD0,
    CMD_EMIT_RD1,
    CMD_EMIT_LATCH,
    CMD_EMIT_PUT,
    CMD_EMPTY_PUT,
    CMD_ADV_START,
    CMD_ADV_RD,
    CMD_ADV_ERD,
    CMD_ADV_WR,
    CMD_FINISH
  } dp_cmd_e;

  typedef struct packed {
    logic scanning;
    logic is_render;
    logic need_div;
    logic div_busy;
    logic table_end;
    logic edge_active;
    logic find_end;
    logic find_hit;
    logic shift_end;
    logic pair_ok;
    logic k_zero;
    logic adv_end;
    logic out_free;
  } dp_status_t;

endpackage

@@ hw/rtl/spf_if.sv @@
// ----------------------------------------------------------------------------
// spf_if: item channels of the scanline polygon fill unit
// Vertex/render command channel and span result channel, valid/ready.
// ----------------------------------------------------------------------------
interface spf_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic signed [15:0] x;
  logic signed [15:0] y;
  logic               last_vertex;

  modport source (output valid, op, x, y, last_vertex, input ready);
  modport sink (input valid, op, x, y, last_vertex, output ready);
endinterface

interface spf_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] line_y;
  logic signed [15:0] span_start;
  logic signed [15:0] span_end;
  logic               span_valid;
  logic               last_span;
  logic               polygon_done;
  logic               edges_dropped;

  modport source (output valid, line_y, span_start, span_end, span_valid, last_span,
                  polygon_done, edges_dropped, input ready);
  modport sink (input valid, line_y, span_start, span_end, span_valid, last_span,
                polygon_done, edges_dropped, output ready);
endinterface

@@ hw/rtl/spf_ram.sv @@
// ----------------------------------------------------------------------------
// spf_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module spf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/spf_div.sv @@
// ----------------------------------------------------------------------------
// spf_div: slope divider
// Restoring division of (|dx| << FRAC_BITS) by |dy|, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module spf_div #(
  parameter int FRAC_BITS = spf_pkg::FracBitsDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [15:0]             dx_mag_i,
  input  logic [15:0]             dy_mag_i,
  output logic                    busy_o,
  output logic [16+FRAC_BITS-1:0] quot_o
);

  localparam int QW = 16 + FRAC_BITS;
  localparam int NW = $clog2(QW + 1);

  logic          busy_q;
  logic [NW-1:0] cnt_q;
  logic [16:0]   rem_q;
  logic [QW-1:0] num_q;
  logic [QW-1:0] quot_q;
  logic [15:0]   den_q;
  logic [16:0]   trial;
  logic          qbit;

  assign trial = {rem_q[15:0], num_q[QW-1]};
  assign qbit  = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= NW'(QW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == NW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      num_q  <= {dx_mag_i, {FRAC_BITS{1'b0}}};
      den_q  <= dy_mag_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= qbit ? (trial - {1'b0, den_q}) : trial;
      num_q  <= {num_q[QW-2:0], 1'b0};
      quot_q <= {quot_q[QW-2:0], qbit};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule

@@ hw/rtl/spf_datapath.sv @@
// ----------------------------------------------------------------------------
// spf_datapath: edge table, active list and span output
// Holds the loader, the edge and active-list memories, the slope divider,
// the scan counters and the output register; executes controller commands.
// ----------------------------------------------------------------------------
module spf_datapath #(
  parameter int MAX_EDGES = spf_pkg::MaxEdgesDefault,
  parameter int FRAC_BITS = spf_pkg::FracBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  spf_pkg::dp_cmd_e    cmd_i,
  output spf_pkg::dp_status_t status_o,
  input  logic                op_i,
  input  logic signed [15:0]  x_i,
  input  logic signed [15:0]  y_i,
  input  logic                last_vertex_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [15:0]  line_y_o,
  output logic signed [15:0]  span_start_o,
  output logic signed [15:0]  span_end_o,
  output logic                span_valid_o,
  output logic                last_span_o,
  output logic                polygon_done_o,
  output logic                edges_dropped_o
);

  localparam int XW = 24 + FRAC_BITS;
  localparam int QW = 16 + FRAC_BITS;
  localparam int IW = $clog2(MAX_EDGES);
  localparam int CW = $clog2(MAX_EDGES + 1);
  localparam int EW = 32 + 2 * XW;
  localparam int LW = IW + XW;
  localparam int KW = spf_pkg::KW;

  function automatic logic signed [15:0] pixel_of(input logic signed [XW-1:0] v);
    logic [XW-1:0]      mag;
    logic [XW-FRAC_BITS-1:0] m;
    logic signed [15:0] r;
    mag = v[XW-1] ? (~v + 1'b1) : v;
    m   = mag[XW-1:FRAC_BITS];
    if (v[XW-1]) begin
      r = (m > (XW-FRAC_BITS)'(32768)) ? -16'sd32768 : 16'(~m[15:0] + 1'b1);
    end else begin
      r = (m > (XW-FRAC_BITS)'(32767)) ? 16'sd32767 : 16'(m[15:0]);
    end
    return r;
  endfunction

  // Loader and scan state.
  logic signed [15:0] prev_x_q, prev_y_q;
  logic               have_prev_q, prev_sep_q;
  logic [CW-1:0]      count_q;
  logic signed [15:0] lo_q, hi_q, line_q, final_q;
  logic               scanning_q, overflow_q, pend_last_q;
  logic signed [15:0] elow_q, ehigh_q;
  logic signed [XW-1:0] ecur_q, newx_q;
  logic               eneg_q;
  logic [CW-1:0]      i_q, j_q, n_q, pos_q;
  logic [KW-1:0]      k_q;
  logic               done_q, drop_q;
  logic [IW-1:0]      aidx_q;
  logic signed [15:0] start_q, end_q;

  // Output register.
  logic               ov_q;
  logic signed [15:0] oly_q, ost_q, oen_q;
  logic               osv_q, ols_q, opd_q, oed_q;
  logic               out_free, push;
  logic signed [15:0] ply, pst, pen;
  logic               psv, pls, ppd, ped;

  // Vertex decode.
  logic               sep, is_edge, full;
  logic signed [16:0] dx, dy;
  logic [16:0]        adx, ady;
  logic               div_start, div_busy;
  logic [QW-1:0]      quot;
  logic [XW-1:0]      qx;
  logic signed [XW-1:0] step;
  logic signed [15:0] lo_nx, hi_nx;

  // Memories.
  logic               e_we, e_re, l_we, l_re;
  logic [IW-1:0]      e_wa, e_ra, l_wa, l_ra;
  logic [EW-1:0]      e_wd, e_rd;
  logic [LW-1:0]      l_wd, l_rd;
  logic signed [15:0] e_low, e_high;
  logic signed [XW-1:0] e_cur, e_step, l_cur;
  logic [IW-1:0]      l_idx;
  logic [CW:0]        j1, j3;
  logic [CW-1:0]      j_m1;

  assign sep     = (x_i == spf_pkg::Separator) && (y_i == spf_pkg::Separator);
  assign is_edge = have_prev_q && !prev_sep_q && !sep && (prev_y_q != y_i);
  assign full    = (count_q == CW'(MAX_EDGES));
  assign dx      = {x_i[15], x_i} - {prev_x_q[15], prev_x_q};
  assign dy      = {y_i[15], y_i} - {prev_y_q[15], prev_y_q};
  assign adx     = dx[16] ? 17'(-dx) : 17'(dx);
  assign ady     = dy[16] ? 17'(-dy) : 17'(dy);
  assign div_start = (cmd_i == spf_pkg::CMD_VERTEX) && is_edge && !full;

  spf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .dx_mag_i (adx[15:0]),
    .dy_mag_i (ady[15:0]),
    .busy_o   (div_busy),
    .quot_o   (quot)
  );

  assign qx    = {{(XW-QW){1'b0}}, quot};
  assign step  = eneg_q ? XW'(-qx) : XW'(qx);
  assign lo_nx = ((count_q == '0) || (elow_q < lo_q)) ? elow_q : lo_q;
  assign hi_nx = ((count_q == '0) || (ehigh_q > hi_q)) ? ehigh_q : hi_q;

  assign e_low  = e_rd[EW-1 -: 16];
  assign e_high = e_rd[EW-17 -: 16];
  assign e_cur  = e_rd[2*XW-1 -: XW];
  assign e_step = e_rd[XW-1:0];
  assign l_idx  = l_rd[LW-1 -: IW];
  assign l_cur  = l_rd[XW-1:0];

  assign j1   = {1'b0, j_q} + (CW+1)'(1);
  assign j3   = {1'b0, j_q} + (CW+1)'(3);
  assign j_m1 = j_q - 1'b1;

  always_comb begin
    e_we = 1'b0;
    e_wa = count_q[IW-1:0];
    e_wd = {elow_q, ehigh_q, ecur_q, step};
    e_re = 1'b0;
    e_ra = i_q[IW-1:0];
    l_we = 1'b0;
    l_wa = j_q[IW-1:0];
    l_wd = l_rd;
    l_re = 1'b0;
    l_ra = j_q[IW-1:0];
    unique case (cmd_i)
      spf_pkg::CMD_EDGE_WRITE: e_we = 1'b1;
      spf_pkg::CMD_SCAN_RD:    e_re = 1'b1;
      spf_pkg::CMD_FIND_RD,
      spf_pkg::CMD_EMIT_RD0,
      spf_pkg::CMD_ADV_RD:     l_re = 1'b1;
      spf_pkg::CMD_SHIFT_RD: begin
        l_re = 1'b1;
        l_ra = j_m1[IW-1:0];
      end
      spf_pkg::CMD_SHIFT_WR:   l_we = 1'b1;
      spf_pkg::CMD_INSERT: begin
        l_we = 1'b1;
        l_wa = pos_q[IW-1:0];
        l_wd = {i_q[IW-1:0], newx_q};
      end
      spf_pkg::CMD_EMIT_RD1: begin
        l_re = 1'b1;
        l_ra = j1[IW-1:0];
      end
      spf_pkg::CMD_ADV_ERD: begin
        e_re = 1'b1;
        e_ra = l_idx;
      end
      spf_pkg::CMD_ADV_WR: begin
        e_we = 1'b1;
        e_wa = aidx_q;
        e_wd = {e_low, e_high, XW'(e_cur + e_step), e_step};
      end
      default: ;
    endcase
  end

  spf_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (e_we),
    .waddr_i (e_wa),
    .wdata_i (e_wd),
    .re_i    (e_re),
    .raddr_i (e_ra),
    .rdata_o (e_rd)
  );

  spf_ram #(.WIDTH(LW), .DEPTH(MAX_EDGES)) u_list_ram (
    .clk_i   (clk_i),
    .we_i    (l_we),
    .waddr_i (l_wa),
    .wdata_i (l_wd),
    .re_i    (l_re),
    .raddr_i (l_ra),
    .rdata_o (l_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      have_prev_q <= 1'b0;
      prev_sep_q  <= 1'b0;
      count_q     <= '0;
      line_q      <= '0;
      final_q     <= '0;
      scanning_q  <= 1'b0;
      overflow_q  <= 1'b0;
      pend_last_q <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      n_q         <= '0;
      pos_q       <= '0;
      k_q         <= '0;
    end else begin
      unique case (cmd_i)
        spf_pkg::CMD_VERTEX: begin
          if (last_vertex_i) begin
            prev_x_q    <= '0;
            prev_y_q    <= '0;
            have_prev_q <= 1'b0;
            prev_sep_q  <= 1'b0;
          end else begin
            prev_x_q    <= x_i;
            prev_y_q    <= y_i;
            have_prev_q <= 1'b1;
            prev_sep_q  <= sep;
          end
          if (is_edge && full) begin
            overflow_q <= 1'b1;
          end
          pend_last_q <= last_vertex_i;
          if (last_vertex_i && !(is_edge && !full) && (count_q != '0)) begin
            scanning_q <= 1'b1;
            line_q     <= lo_q;
            final_q    <= hi_q;
          end
        end
        spf_pkg::CMD_EDGE_WRITE: begin
          count_q <= count_q + 1'b1;
          if (pend_last_q) begin
            scanning_q <= 1'b1;
            line_q     <= lo_nx;
            final_q    <= hi_nx;
          end
        end
        spf_pkg::CMD_RENDER_START: begin
          i_q <= '0;
          n_q <= '0;
        end
        spf_pkg::CMD_SCAN_SKIP: i_q <= i_q + 1'b1;
        spf_pkg::CMD_SCAN_TAKE: j_q <= '0;
        spf_pkg::CMD_FIND_NEXT: j_q <= j_q + 1'b1;
        spf_pkg::CMD_FIND_STOP: begin
          pos_q <= j_q;
          j_q   <= n_q;
        end
        spf_pkg::CMD_SHIFT_WR: j_q <= j_m1;
        spf_pkg::CMD_INSERT: begin
          n_q <= n_q + 1'b1;
          i_q <= i_q + 1'b1;
        end
        spf_pkg::CMD_EMIT_START: begin
          j_q <= '0;
          k_q <= '0;
        end
        spf_pkg::CMD_EMIT_PUT: begin
          j_q <= CW'(j_q + CW'(2));
          k_q <= k_q + 1'b1;
        end
        spf_pkg::CMD_EMPTY_PUT,
        spf_pkg::CMD_ADV_START: j_q <= '0;
        spf_pkg::CMD_ADV_WR:    j_q <= j_q + 1'b1;
        spf_pkg::CMD_FINISH: begin
          if (done_q) begin
            scanning_q <= 1'b0;
            count_q    <= '0;
            overflow_q <= 1'b0;
          end else begin
            line_q <= line_q + 16'sd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i)
      spf_pkg::CMD_VERTEX: begin
        if (prev_y_q < y_i) begin
          elow_q  <= prev_y_q;
          ehigh_q <= y_i;
          ecur_q  <= {{(XW-16-FRAC_BITS){prev_x_q[15]}}, prev_x_q, {FRAC_BITS{1'b0}}};
        end else begin
          elow_q  <= y_i;
          ehigh_q <= prev_y_q;
          ecur_q  <= {{(XW-16-FRAC_BITS){x_i[15]}}, x_i, {FRAC_BITS{1'b0}}};
        end
        eneg_q <= dx[16] ^ dy[16];
      end
      spf_pkg::CMD_EDGE_WRITE: begin
        lo_q <= lo_nx;
        hi_q <= hi_nx;
      end
      spf_pkg::CMD_RENDER_START: begin
        done_q <= (line_q >= final_q);
        drop_q <= overflow_q;
      end
      spf_pkg::CMD_SCAN_TAKE:  newx_q  <= e_cur;
      spf_pkg::CMD_EMIT_RD1:   start_q <= pixel_of(l_cur);
      spf_pkg::CMD_EMIT_LATCH: end_q   <= pixel_of(l_cur);
      spf_pkg::CMD_ADV_ERD:    aidx_q  <= l_idx;
      default: ;
    endcase
  end

  // Result builder.
  assign out_free = !ov_q || out_ready_i;

  always_comb begin
    push = 1'b1;
    ply  = line_q;
    pst  = '0;
    pen  = '0;
    psv  = 1'b0;
    pls  = 1'b1;
    ppd  = done_q;
    ped  = drop_q;
    unique case (cmd_i)
      spf_pkg::CMD_IDLE_PUT: begin
        ply = '0;
        ppd = 1'b1;
        ped = 1'b0;
      end
      spf_pkg::CMD_EMIT_PUT: begin
        pst = start_q;
        pen = end_q;
        psv = 1'b1;
        pls = !((j3 < {1'b0, n_q}) && ((k_q + 1'b1) < KW'(spf_pkg::MaxSpans)));
      end
      spf_pkg::CMD_EMPTY_PUT: ;
      default: push = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (push) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      oly_q <= ply;
      ost_q <= pst;
      oen_q <= pen;
      osv_q <= psv;
      ols_q <= pls;
      opd_q <= ppd;
      oed_q <= ped;
    end
  end

  assign out_valid_o     = ov_q;
  assign line_y_o        = oly_q;
  assign span_start_o    = ost_q;
  assign span_end_o      = oen_q;
  assign span_valid_o    = osv_q;
  assign last_span_o     = ols_q;
  assign polygon_done_o  = opd_q;
  assign edges_dropped_o = oed_q;

  always_comb begin
    status_o             = '0;
    status_o.scanning    = scanning_q;
    status_o.is_render   = op_i;
    status_o.need_div    = is_edge && !full;
    status_o.div_busy    = div_busy;
    status_o.table_end   = (i_q == count_q);
    status_o.edge_active = (e_low <= line_q) && (e_high > line_q);
    status_o.find_end    = (j_q == n_q);
    status_o.find_hit    = (l_cur > newx_q);
    status_o.shift_end   = (j_q == pos_q);
    status_o.pair_ok     = (j1 < {1'b0, n_q}) && (k_q < KW'(spf_pkg::MaxSpans));
    status_o.k_zero      = (k_q == '0);
    status_o.adv_end     = (j_q == n_q);
    status_o.out_free    = out_free;
  end

endmodule

@@ hw/rtl/spf_ctrl.sv @@
// ----------------------------------------------------------------------------
// spf_ctrl: sequencer of the scanline polygon fill unit
// Walks vertex loading, the edge scan with insertion sort, span output and
// the slope advance, issuing at most one datapath command per cycle.
// ----------------------------------------------------------------------------
module spf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  spf_pkg::dp_status_t status_i,
  output spf_pkg::dp_cmd_e    cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_DIV, S_IDLE_OUT, S_SCAN_RD, S_SCAN_CHK, S_FIND_RD, S_FIND_CHK,
    S_SHIFT_RD, S_SHIFT_WR, S_EMIT_CHK, S_EMIT_RD1, S_EMIT_LAT, S_EMIT_PUT,
    S_EMPTY_PUT, S_ADV_RD, S_ADV_ERD, S_ADV_WR
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = spf_pkg::CMD_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (status_i.is_render) begin
            if (status_i.scanning) begin
              cmd_o   = spf_pkg::CMD_RENDER_START;
              state_d = S_SCAN_RD;
            end else begin
              state_d = S_IDLE_OUT;
            end
          end else if (!status_i.scanning) begin
            cmd_o = spf_pkg::CMD_VERTEX;
            if (status_i.need_div) begin
              state_d = S_DIV;
            end
          end
        end
      end
      S_DIV: begin
        if (!status_i.div_busy) begin
          cmd_o   = spf_pkg::CMD_EDGE_WRITE;
          state_d = S_IDLE;
        end
      end
      S_IDLE_OUT: begin
        if (status_i.out_free) begin
          cmd_o   = spf_pkg::CMD_IDLE_PUT;
          state_d = S_IDLE;
        end
      end
      S_SCAN_RD: begin
        if (status_i.table_end) begin
          cmd_o   = spf_pkg::CMD_EMIT_START;
          state_d = S_EMIT_CHK;
        end else begin
          cmd_o   = spf_pkg::CMD_SCAN_RD;
          state_d = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (status_i.edge_active) begin
          cmd_o   = spf_pkg::CMD_SCAN_TAKE;
          state_d = S_FIND_RD;
        end else begin
          cmd_o   = spf_pkg::CMD_SCAN_SKIP;
          state_d = S_SCAN_RD;
        end
      end
      S_FIND_RD: begin
        if (status_i.find_end) begin
          cmd_o   = spf_pkg::CMD_FIND_STOP;
          state_d = S_SHIFT_RD;
        end else begin
          cmd_o   = spf_pkg::CMD_FIND_RD;
          state_d = S_FIND_CHK;
        end
      end
      S_FIND_CHK: begin
        if (status_i.find_hit) begin
          cmd_o   = spf_pkg::CMD_FIND_STOP;
          state_d = S_SHIFT_RD;
        end else begin
          cmd_o   = spf_pkg::CMD_FIND_NEXT;
          state_d = S_FIND_RD;
        end
      end
      S_SHIFT_RD: begin
        if (status_i.shift_end) begin
          cmd_o   = spf_pkg::CMD_INSERT;
          state_d = S_SCAN_RD;
        end else begin
          cmd_o   = spf_pkg::CMD_SHIFT_RD;
          state_d = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd_o   = spf_pkg::CMD_SHIFT_WR;
        state_d = S_SHIFT_RD;
      end
      S_EMIT_CHK: begin
        if (status_i.pair_ok) begin
          cmd_o   = spf_pkg::CMD_EMIT_RD0;
          state_d = S_EMIT_RD1;
        end else if (status_i.k_zero) begin
          state_d = S_EMPTY_PUT;
        end else begin
          cmd_o   = spf_pkg::CMD_ADV_START;
          state_d = S_ADV_RD;
        end
      end
      S_EMIT_RD1: begin
        cmd_o   = spf_pkg::CMD_EMIT_RD1;
        state_d = S_EMIT_LAT;
      end
      S_EMIT_LAT: begin
        cmd_o   = spf_pkg::CMD_EMIT_LATCH;
        state_d = S_EMIT_PUT;
      end
      S_EMIT_PUT: begin
        if (status_i.out_free) begin
          cmd_o   = spf_pkg::CMD_EMIT_PUT;
          state_d = S_EMIT_CHK;
        end
      end
      S_EMPTY_PUT: begin
        if (status_i.out_free) begin
          cmd_o   = spf_pkg::CMD_EMPTY_PUT;
          state_d = S_ADV_RD;
        end
      end
      S_ADV_RD: begin
        if (status_i.adv_end) begin
          cmd_o   = spf_pkg::CMD_FINISH;
          state_d = S_IDLE;
        end else begin
          cmd_o   = spf_pkg::CMD_ADV_RD;
          state_d = S_ADV_ERD;
        end
      end
      S_ADV_ERD: begin
        cmd_o   = spf_pkg::CMD_ADV_ERD;
        state_d = S_ADV_WR;
      end
      S_ADV_WR: begin
        cmd_o   = spf_pkg::CMD_ADV_WR;
        state_d = S_ADV_RD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

@@ hw/rtl/scanline_polygon_fill_unit.sv @@
// ----------------------------------------------------------------------------
// scanline_polygon_fill_unit: scanline polygon filler with active edge table
// A vertex item that closes an edge waits for the bit-serial slope divider.
// A scanline render item scans the edge table, sorts each active edge into
// the active list, emits the spans and advances the edges; its time is set
// by the single read port of the edge and active-list memories, and output
// stalls add to it. Results pass through one output register, so the next
// item is taken while the last result still waits.
// ----------------------------------------------------------------------------
module scanline_polygon_fill_unit #(
  parameter int MAX_EDGES = spf_pkg::MaxEdgesDefault,
  parameter int FRAC_BITS = spf_pkg::FracBitsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  spf_in_if.sink    in_i,
  spf_out_if.source out_o
);

  spf_pkg::dp_cmd_e    cmd;
  spf_pkg::dp_status_t status;

  spf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  spf_datapath #(
    .MAX_EDGES (MAX_EDGES),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .op_i            (in_i.op),
    .x_i             (in_i.x),
    .y_i             (in_i.y),
    .last_vertex_i   (in_i.last_vertex),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .line_y_o        (out_o.line_y),
    .span_start_o    (out_o.span_start),
    .span_end_o      (out_o.span_end),
    .span_valid_o    (out_o.span_valid),
    .last_span_o     (out_o.last_span),
    .polygon_done_o  (out_o.polygon_done),
    .edges_dropped_o (out_o.edges_dropped)
  );

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench of the scanline polygon fill unit
// Loads polygons vertex by vertex and renders every scanline. A software copy
// of the edge table predicts each span, and every result item is compared
// field by field. Both channels idle at random, and the receiver holds off
// for one long stretch so that the input channel backs up.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct {
    logic signed [15:0] line_y;
    logic signed [15:0] span_start;
    logic signed [15:0] span_end;
    bit                 span_valid;
    bit                 last_span;
    bit                 polygon_done;
    bit                 edges_dropped;
  } span_t;

  localparam int EdgeCap = spf_pkg::MaxEdgesDefault;
  localparam int Frac    = spf_pkg::FracBitsDefault;

  logic clk_i;
  logic rst_ni;
  spf_in_if  in_if ();
  spf_out_if out_if ();

  scanline_polygon_fill_unit uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  span_t   exp_spans[$];
  int      errors;
  bit      no_idle;
  int      hold_cycles;

  int      ld_x, ld_y;
  bit      ld_have, ld_sep;
  int      edge_lo[EdgeCap];
  int      edge_hi[EdgeCap];
  longint  edge_x[EdgeCap];
  longint  edge_dx[EdgeCap];
  int      edge_num;
  int      act[EdgeCap];
  int      line_now, scan_last;
  bit      scan_on, dropped;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic longint slope(int dx, int dy);
    longint ax, ay, q;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    if (ay == 0) return 0;
    q = (ax <<< Frac) / ay;
    return ((dx < 0) != (dy < 0)) ? -q : q;
  endfunction

  function automatic logic signed [15:0] pixel(longint v);
    longint r;
    r = ((v < 0) ? -v : v) >>> Frac;
    if (v < 0) r = -r;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic void push_span(int ly, int s, int e, bit sv, bit ls, bit pd, bit ed);
    span_t t;
    t.line_y = ly[15:0];
    t.span_start = s[15:0];
    t.span_end = e[15:0];
    t.span_valid = sv;
    t.last_span = ls;
    t.polygon_done = pd;
    t.edges_dropped = ed;
    exp_spans.push_back(t);
  endfunction

  function automatic void load_vertex(int x, int y, bit fin);
    bit sep;
    int lo, hi;
    sep = (x == spf_pkg::Separator && y == spf_pkg::Separator);
    if (ld_have && !ld_sep && !sep && ld_y != y) begin
      if (edge_num >= EdgeCap) begin
        dropped = 1'b1;
      end else begin
        if (ld_y < y) begin
          edge_lo[edge_num] = ld_y;
          edge_hi[edge_num] = y;
          edge_x[edge_num] = longint'(ld_x) <<< Frac;
        end else begin
          edge_lo[edge_num] = y;
          edge_hi[edge_num] = ld_y;
          edge_x[edge_num] = longint'(x) <<< Frac;
        end
        edge_dx[edge_num] = slope(x - ld_x, y - ld_y);
        edge_num++;
      end
    end
    ld_x = x;
    ld_y = y;
    ld_have = 1'b1;
    ld_sep = sep;
    if (fin) begin
      ld_have = 1'b0;
      ld_sep = 1'b0;
      ld_x = 0;
      ld_y = 0;
      if (edge_num > 0) begin
        lo = edge_lo[0];
        hi = edge_hi[0];
        for (int i = 1; i < edge_num; i++) begin
          if (edge_lo[i] < lo) lo = edge_lo[i];
          if (edge_hi[i] > hi) hi = edge_hi[i];
        end
        line_now = lo;
        scan_last = hi;
        scan_on = 1'b1;
      end
    end
  endfunction

  function automatic void render_line();
    int  y, n, pos, k;
    bit  done;
    y = line_now;
    done = (y >= scan_last);
    n = 0;
    k = 0;
    for (int i = 0; i < edge_num; i++) begin
      if (edge_lo[i] <= y && edge_hi[i] > y) begin
        pos = n;
        for (int j = 0; j < n; j++) begin
          if (edge_x[act[j]] > edge_x[i]) begin
            pos = j;
            break;
          end
        end
        for (int j = n; j > pos; j--) act[j] = act[j-1];
        act[pos] = i;
        n++;
      end
    end
    for (int i = 0; i + 1 < n && k < spf_pkg::MaxSpans; i += 2) begin
      push_span(y, pixel(edge_x[act[i]]), pixel(edge_x[act[i+1]]), 1'b1, 1'b0, done, dropped);
      k++;
    end
    for (int i = 0; i < n; i++) edge_x[act[i]] += edge_dx[act[i]];
    if (k == 0) push_span(y, 0, 0, 1'b0, 1'b1, done, dropped);
    else exp_spans[exp_spans.size()-1].last_span = 1'b1;
    if (done) begin
      scan_on = 1'b0;
      edge_num = 0;
      dropped = 1'b0;
    end else begin
      line_now = y + 1;
    end
  endfunction

  function automatic void predict(bit op, int x, int y, bit fin);
    if (!op) begin
      if (!scan_on) load_vertex(x, y, fin);
    end else if (!scan_on) begin
      push_span(0, 0, 0, 1'b0, 1'b1, 1'b1, 1'b0);
    end else begin
      render_line();
    end
  endfunction

  task automatic send_item(bit op, int x, int y, bit fin);
    int gap;
    @(negedge clk_i);
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 7);
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.op <= op;
    in_if.x <= x[15:0];
    in_if.y <= y[15:0];
    in_if.last_vertex <= fin;
    do @(posedge clk_i); while (!in_if.ready);
    predict(op, int'($signed(x[15:0])), int'($signed(y[15:0])), fin);
  endtask

  task automatic vertex(int x, int y, bit fin = 1'b0);
    send_item(1'b0, x, y, fin);
  endtask

  task automatic render_all();
    while (scan_on) send_item(1'b1, $urandom, $urandom, $urandom_range(0, 1));
  endtask

  task automatic report(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  initial begin
    out_if.ready = 1'b0;
    forever begin
      int stall;
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_if.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_if.ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 7) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    span_t e;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (exp_spans.size() == 0) begin
        report($sformatf("unexpected result line %0d", out_if.line_y));
      end else begin
        e = exp_spans.pop_front();
        if (out_if.line_y !== e.line_y)
          report($sformatf("line_y %0d, want %0d", out_if.line_y, e.line_y));
        if (out_if.span_start !== e.span_start)
          report($sformatf("span_start %0d, want %0d", out_if.span_start, e.span_start));
        if (out_if.span_end !== e.span_end)
          report($sformatf("span_end %0d, want %0d", out_if.span_end, e.span_end));
        if (out_if.span_valid !== e.span_valid) report("span_valid differs");
        if (out_if.last_span !== e.last_span) report("last_span differs");
        if (out_if.polygon_done !== e.polygon_done) report("polygon_done differs");
        if (out_if.edges_dropped !== e.edges_dropped) report("edges_dropped differs");
      end
    end
  end

  task automatic test_idle();
    send_item(1'b1, 0, 0, 1'b0);
    vertex(3, 4, 1'b1);
    send_item(1'b1, -1, -1, 1'b1);
  endtask

  task automatic test_square();
    vertex(0, 0);
    vertex(10, 0);
    vertex(10, 5);
    vertex(0, 5);
    vertex(0, 0, 1'b1);
    send_item(1'b1, 0, 0, 1'b0);
    vertex(100, 100, 1'b1);
    render_all();
  endtask

  task automatic test_extremes();
    vertex(-32768, -32768);
    vertex(32767, -32765);
    vertex(spf_pkg::Separator, spf_pkg::Separator);
    vertex(-32768, -32765);
    vertex(32767, -32768);
    vertex(-32768, -32766, 1'b1);
    render_all();
    vertex(5, 32767);
    vertex(-32768, 32760);
    vertex(32767, 32766);
    vertex(-21846, 32767);
    vertex(21845, 32761, 1'b1);
    render_all();
  endtask

  task automatic test_ties_odd();
    vertex(0, 0);
    vertex(5, 3);
    vertex(9, 0);
    vertex(5, 3);
    vertex(12, -2, 1'b1);
    render_all();
  endtask

  task automatic test_overflow();
    for (int i = 0; i < EdgeCap + 2; i++) vertex($urandom_range(0, 200) - 100, i % 2);
    vertex(7, 5, 1'b1);
    render_all();
  endtask

  task automatic test_backpressure();
    hold_cycles = 400;
    vertex(-20, 0);
    vertex(20, 4);
    vertex(40, -3);
    vertex(-20, 0, 1'b1);
    render_all();
  endtask

  task automatic test_random(int polys);
    int base, nv, xr, x, y;
    for (int p = 0; p < polys; p++) begin
      base = $urandom_range(0, 65535 - 16) - 32768;
      nv = $urandom_range(2, 8);
      xr = ($urandom_range(0, 3) == 0) ? 32767 : 50;
      for (int v = 0; v < nv; v++) begin
        if ($urandom_range(0, 9) == 0) begin
          vertex(spf_pkg::Separator, spf_pkg::Separator);
        end else begin
          x = $urandom_range(0, 2 * xr) - xr;
          y = base + $urandom_range(0, 6);
          vertex(x, y, v == nv - 1);
        end
      end
      if ($urandom_range(0, 3) == 0) send_item(1'b1, 0, 0, 1'b0);
      while (scan_on) begin
        if ($urandom_range(0, 9) == 0) vertex($urandom, $urandom, $urandom_range(0, 1));
        else send_item(1'b1, $urandom, $urandom, 1'b0);
      end
    end
  endtask

  initial begin
    int waited;
    errors = 0;
    no_idle = 1'b0;
    hold_cycles = 0;
    edge_num = 0;
    scan_on = 1'b0;
    dropped = 1'b0;
    ld_have = 1'b0;
    ld_sep = 1'b0;
    ld_x = 0;
    ld_y = 0;
    line_now = 0;
    scan_last = 0;
    in_if.valid = 1'b0;
    in_if.op = 1'b0;
    in_if.x = '0;
    in_if.y = '0;
    in_if.last_vertex = 1'b0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_idle();
    test_square();
    test_extremes();
    test_ties_odd();
    test_overflow();
    test_backpressure();
    test_random(2);
    no_idle = 1'b1;
    test_random(1);

    @(negedge clk_i);
    in_if.valid <= 1'b0;
    waited = 0;
    while (exp_spans.size() != 0 && waited < 200000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (300) @(posedge clk_i);
    if (errors == 0 && exp_spans.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
